// ----- rtl/core/ordered_list_store_unit_defines.svh -----
// ============================================================================
// ordered_list_store_unit_defines.svh
// assertion macros shared by the ordered list store checkers
// ============================================================================
`ifndef ORDERED_LIST_STORE_UNIT_DEFINES_SVH
`define ORDERED_LIST_STORE_UNIT_DEFINES_SVH

// same-cycle implication
`define OLSU_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ordered list store check failed");

// next-cycle implication
`define OLSU_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ordered list store check failed");

`endif

// ----- rtl/core/olsu_pkg.sv -----
// ============================================================================
// olsu_pkg
// types, codes and widths shared by the ordered list store unit
// ============================================================================
package olsu_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CMD_W        = 2;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_FIND      = 2'd3
    } olsu_op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic scan_start;
        logic out_load;
    } olsu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic scan_done;
    } olsu_stat_t;

endpackage

// ----- rtl/core/olsu_in_if.sv -----
// ============================================================================
// olsu_in_if
// command channel: valid/ready with command and value payload
// ============================================================================
interface olsu_in_if;
    import olsu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface

// ----- rtl/core/olsu_out_if.sv -----
// ============================================================================
// olsu_out_if
// result channel: valid/ready with found, status and count payload
// ============================================================================
interface olsu_out_if;
    import olsu_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, output found, output status,
        output removed_count, output entry_count, input ready
    );
    modport sink (
        input valid, input found, input status,
        input removed_count, input entry_count, output ready
    );

endinterface

// ----- rtl/core/olsu_ram.sv -----
// ============================================================================
// olsu_ram
// generic simple dual-port ram, one write port, one registered read port
// ============================================================================
module olsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/olsu_ctrl.sv -----
// ============================================================================
// olsu_ctrl
// command sequencer: accept, execute, scan wait and result handoff
// ============================================================================
module olsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output olsu_pkg::olsu_cmd_t  cmd,
    input  olsu_pkg::olsu_stat_t stat
);
    import olsu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_insert)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/olsu_dp.sv -----
// ============================================================================
// olsu_dp
// entry ram as a ring with head pointer, insert logic, scan and compaction
// ============================================================================
module olsu_dp #(
    parameter int CAPACITY = olsu_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  olsu_pkg::olsu_cmd_t                 cmd,
    output olsu_pkg::olsu_stat_t                stat,
    input  logic [olsu_pkg::CMD_W-1:0]          in_command,
    input  logic signed [olsu_pkg::VALUE_W-1:0] in_value,
    output logic                                found,
    output logic                                status,
    output logic [olsu_pkg::COUNT_W-1:0]        removed_count,
    output logic [olsu_pkg::COUNT_W-1:0]        entry_count
);
    import olsu_pkg::*;

    localparam int             AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int             CW    = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0]  LAST  = AW'(CAPACITY - 1);
    localparam logic [CW-1:0]  FULL  = CW'(CAPACITY);
    localparam logic [AW:0]    CAP_X = (AW + 1)'(CAPACITY);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // control state
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          scan_reg, scan_next;
    logic          rd_vld_reg, rd_vld_next;

    // per-command working registers
    olsu_op_t           op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic [CW-1:0]      keep_reg, keep_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic               found_reg, found_next;
    logic               status_reg, status_next;

    // result register
    logic               res_found_reg, res_status_reg;
    logic [COUNT_W-1:0] res_removed_reg, res_count_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    logic          match, issue_more, done, keep_write, full, is_remove;
    logic [AW-1:0] front_head, back_addr;
    logic [AW:0]   back_sum;

    olsu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign is_remove  = (op_reg == CMD_REMOVE);
    assign match      = (ram_rdata == value_reg);
    assign issue_more = scan_reg && (issue_reg != occ_reg);
    assign done       = scan_reg && !issue_more && !rd_vld_reg;
    assign keep_write = rd_vld_reg && !match && is_remove;
    assign full       = (occ_reg == FULL);
    assign front_head = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign back_sum   = {1'b0, head_reg} + (AW + 1)'(occ_reg);
    assign back_addr  = (back_sum >= CAP_X) ? AW'(back_sum - CAP_X) : back_sum[AW-1:0];

    assign ram_we    = (cmd.insert && !full) || keep_write;
    assign ram_waddr = keep_write ? wr_ptr_reg
                     : ((op_reg == CMD_INS_FRONT) ? front_head : back_addr);
    assign ram_wdata = keep_write ? ram_rdata : value_reg;

    always_comb
    begin
        head_next    = head_reg;
        occ_next     = occ_reg;
        scan_next    = scan_reg;
        rd_vld_next  = issue_more;
        op_next      = op_reg;
        value_next   = value_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        issue_next   = issue_reg;
        keep_next    = keep_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        status_next  = status_reg;

        if (cmd.load)
        begin
            op_next      = olsu_op_t'(in_command);
            value_next   = in_value;
            rd_ptr_next  = head_reg;
            wr_ptr_next  = head_reg;
            issue_next   = '0;
            keep_next    = '0;
            removed_next = '0;
            found_next   = 1'b0;
            status_next  = 1'b0;
        end

        if (cmd.insert)
        begin
            if (full)
            begin
                status_next = 1'b1;
            end
            else
            begin
                occ_next = occ_reg + CW'(1);
                if (op_reg == CMD_INS_FRONT)
                begin
                    head_next = front_head;
                end
            end
        end

        if (cmd.scan_start)
        begin
            scan_next = 1'b1;
        end

        if (issue_more)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            issue_next  = issue_reg + CW'(1);
        end

        if (rd_vld_reg)
        begin
            if (match)
            begin
                if (is_remove)
                begin
                    removed_next = removed_reg + CW'(1);
                end
                else
                begin
                    found_next = 1'b1;
                end
            end
            else if (is_remove)
            begin
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                keep_next   = keep_reg + CW'(1);
            end
        end

        if (done)
        begin
            scan_next = 1'b0;
            if (is_remove)
            begin
                occ_next = keep_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            occ_reg    <= '0;
            scan_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            occ_reg    <= occ_next;
            scan_reg   <= scan_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        issue_reg   <= issue_next;
        keep_reg    <= keep_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        if (cmd.out_load)
        begin
            res_found_reg   <= found_reg;
            res_status_reg  <= status_reg;
            res_removed_reg <= COUNT_W'(removed_reg);
            res_count_reg   <= COUNT_W'(occ_reg);
        end
    end

    assign stat.is_insert = (op_reg == CMD_INS_FRONT) || (op_reg == CMD_INS_BACK);
    assign stat.scan_done = done;

    assign found         = res_found_reg;
    assign status        = res_status_reg;
    assign removed_count = res_removed_reg;
    assign entry_count   = res_count_reg;

endmodule

// ----- rtl/core/ordered_list_store_unit.sv -----
// ============================================================================
// ordered_list_store_unit
// ordered store of signed 32-bit values with front/back insert, remove, find
// ----------------------------------------------------------------------------
// in_ch carries one command (insert front, insert back, remove all equal,
// find) with a value; out_ch returns exactly one result per command with
// found, status (insert dropped on full store), removed_count, entry_count.
// a transfer happens on a rising edge with valid and ready both high.
// entries live in a single ram used as a ring, front at a head pointer.
// one command is in work at a time; in_ch.ready is high only when idle.
// insert goes through accept, insert and result handoff in that order.
// remove/find go through accept, scan start, a scan of the n stored
// entries and result handoff; the scan is paced by the single
// read port of the entry ram, which reads one entry per cycle.
// the result sits in an output register, so the next command is accepted
// while the previous result waits; a stalled out_ch holds the result and
// the finished command waits for the register to free up.
// reset empties the store at once (count cleared, no ram sweep); entries
// are only read after they were written.
// counts above 31 (capacity over 31) show their low 5 bits.
// ============================================================================
module ordered_list_store_unit #(
    parameter int CAPACITY = olsu_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    olsu_in_if.sink     in_ch,
    olsu_out_if.source  out_ch
);
    import olsu_pkg::*;

    olsu_cmd_t  cmd;
    olsu_stat_t stat;

    olsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    olsu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_command    (in_ch.command),
        .in_value      (in_ch.value),
        .found         (out_ch.found),
        .status        (out_ch.status),
        .removed_count (out_ch.removed_count),
        .entry_count   (out_ch.entry_count)
    );

endmodule

// ----- rtl/core/olsu_checker.sv -----
// ============================================================================
// olsu_checker
// port-level checks for the ordered list store unit, bound to the top level
// ============================================================================
`include "ordered_list_store_unit_defines.svh"

module olsu_checker #(
    parameter int CAPACITY = olsu_pkg::CAPACITY_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         found,
    input logic                         status,
    input logic [olsu_pkg::COUNT_W-1:0] removed_count,
    input logic [olsu_pkg::COUNT_W-1:0] entry_count
);
    import olsu_pkg::*;

    localparam bit                 COUNT_WRAPS = (CAPACITY > 31);
    localparam logic [COUNT_W-1:0] COUNT_CAP   = COUNT_W'(CAPACITY);

    logic                     stalled;
    logic [2*COUNT_W+1:0]     res_bits;

    assign stalled  = out_valid && !out_ready;
    assign res_bits = {found, status, removed_count, entry_count};

    // one command in work at a time
    `OLSU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // stalled result holds
    `OLSU_ASSERT_NXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(res_bits))

    // dropped insert reports nothing else
    `OLSU_ASSERT_IMP(a_drop_clean, clk, rst_n, out_valid && status, !found && (removed_count == '0))

    // find hit is never an insert or remove
    `OLSU_ASSERT_IMP(a_found_clean, clk, rst_n, out_valid && found, !status && (removed_count == '0))

    // count never exceeds capacity
    `OLSU_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, COUNT_WRAPS || (entry_count <= COUNT_CAP))

endmodule

bind ordered_list_store_unit olsu_checker #(
    .CAPACITY (CAPACITY)
) u_olsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .found         (out_ch.found),
    .status        (out_ch.status),
    .removed_count (out_ch.removed_count),
    .entry_count   (out_ch.entry_count)
);
